/* sv/assert_macros.svh */
// Assertion macros used by the checker of this project.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay between cause and consequence.
`define QSS_ASSERT_AFTER(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* sv/qss_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the quadrilateral span block.
// Used by the edge lane, the top level and the checker; depends on nothing.
package qss_pkg;

  localparam int CORNER_W = 24;
  localparam int FRAC_W   = 8;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 10;
  localparam int RFIX_W   = ROW_W + FRAC_W;
  localparam int PIX_W    = 17;
  localparam int QUO_W    = 16;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Edge lane: four arithmetic stages, one stage per quotient bit, one output stage.
  localparam int LANE_LAT  = QUO_W + 5;
  // From the accepting edge to the edge that takes the result.
  localparam int TOTAL_LAT = LANE_LAT + 4;

  localparam int DEF_SCREEN_WIDTH  = 1024;
  localparam int DEF_SCREEN_HEIGHT = 1024;

  typedef logic signed [CORNER_W-1:0] coord_t;

  typedef enum logic [2:0] {
    REG_C0X, REG_C0Y, REG_C1X, REG_C1Y, REG_C2X, REG_C2Y, REG_C3X, REG_C3Y
  } qss_reg_t;

  typedef struct packed {
    logic                    any;
    logic signed [PIX_W-1:0] lo;
    logic signed [PIX_W-1:0] hi;
  } span_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] bx0;
    logic signed [PIX_W-1:0] bx1;
    logic signed [PIX_W-1:0] by0;
    logic signed [PIX_W-1:0] by1;
  } bbox_t;

  // Whole-pixel part of a fixed-point coordinate, rounded toward zero.
  function automatic logic signed [PIX_W-1:0] trunc_px(input coord_t c);
    coord_t adj;
    adj = c[CORNER_W-1] ? c + coord_t'(2**FRAC_W - 1) : c;
    return PIX_W'(adj >>> FRAC_W);
  endfunction

  // Least low end and greatest high end of two partial spans.
  function automatic span_t merge_span(input span_t a, input span_t b);
    span_t m;
    m.any = a.any | b.any;
    if (!a.any) begin
      m.lo = b.lo;
      m.hi = b.hi;
    end else if (!b.any) begin
      m.lo = a.lo;
      m.hi = a.hi;
    end else begin
      m.lo = (b.lo < a.lo) ? b.lo : a.lo;
      m.hi = (b.hi > a.hi) ? b.hi : a.hi;
    end
    return m;
  endfunction

endpackage

/* sv/quad_scanline_span.sv */
`timescale 1ns / 1ps
// Top level of the quadrilateral row span block: register port, edge lanes, span merge.
// Depends on qss_pkg and qss_edge_lane.
//
// Use: write the four corners (signed, 8 fraction bits) through the APB port,
// registers corner0_x .. corner3_y at byte addresses 0, 4, .. 28. Reads return
// the stored 24-bit value zero-extended. Write only while no row is in flight.
// A row is requested by raising start with in_row; busy is always low, so a
// transaction is taken at every edge where start is high, one row per cycle.
// The result sits on out_span_* with out_strobe for exactly one cycle; the
// depth is set by the edge lanes, each with its 16-stage divider, plus the
// merge and clamp stages. Results leave in request order. The receiver cannot
// hold results off and never needs to.
// Reset (synchronous, active low) clears the corners to zero and drops every
// row in flight; no strobe follows a row accepted before reset.
module quad_scanline_span #(
  parameter int SCREEN_WIDTH  = qss_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = qss_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [qss_pkg::ROW_W-1:0]     in_row,
  output logic                          out_strobe,
  output logic                          out_span_valid,
  output logic [qss_pkg::COL_W-1:0]     out_span_xmin,
  output logic [qss_pkg::COL_W-1:0]     out_span_xmax,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qss_pkg::ADDR_W-1:0]    paddr,
  input  logic [qss_pkg::DATA_W-1:0]    pwdata,
  output logic [qss_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import qss_pkg::*;

  localparam logic signed [PIX_W-1:0] XLIM = PIX_W'(SCREEN_WIDTH - 1);
  localparam logic signed [PIX_W-1:0] YLIM = PIX_W'(SCREEN_HEIGHT - 1);
  localparam int                      OUT_IDX = LANE_LAT + 3;

  // Register port.
  coord_t   cx_r [0:3];
  coord_t   cy_r [0:3];
  qss_reg_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = qss_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
      end
    end else if (wr_en) begin
      case (reg_idx)
        REG_C0X: cx_r[0] <= pwdata[CORNER_W-1:0];
        REG_C0Y: cy_r[0] <= pwdata[CORNER_W-1:0];
        REG_C1X: cx_r[1] <= pwdata[CORNER_W-1:0];
        REG_C1Y: cy_r[1] <= pwdata[CORNER_W-1:0];
        REG_C2X: cx_r[2] <= pwdata[CORNER_W-1:0];
        REG_C2Y: cy_r[2] <= pwdata[CORNER_W-1:0];
        REG_C3X: cx_r[3] <= pwdata[CORNER_W-1:0];
        REG_C3Y: cy_r[3] <= pwdata[CORNER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_C0X: prdata = {{(DATA_W-CORNER_W){1'b0}}, cx_r[0]};
      REG_C0Y: prdata = {{(DATA_W-CORNER_W){1'b0}}, cy_r[0]};
      REG_C1X: prdata = {{(DATA_W-CORNER_W){1'b0}}, cx_r[1]};
      REG_C1Y: prdata = {{(DATA_W-CORNER_W){1'b0}}, cy_r[1]};
      REG_C2X: prdata = {{(DATA_W-CORNER_W){1'b0}}, cx_r[2]};
      REG_C2Y: prdata = {{(DATA_W-CORNER_W){1'b0}}, cy_r[2]};
      REG_C3X: prdata = {{(DATA_W-CORNER_W){1'b0}}, cx_r[3]};
      REG_C3Y: prdata = {{(DATA_W-CORNER_W){1'b0}}, cy_r[3]};
      default: prdata = '0;
    endcase
  end

  // Valid bits travel alongside the row through every stage.
  logic [OUT_IDX:0]   v_r;
  logic [ROW_W-1:0]   row_r, row_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[OUT_IDX-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= in_row;
    row_b_r <= row_r;
  end

  // Bounding box of the truncated corners, clipped to the screen, then the row test.
  bbox_t                   bbox_nxt, bbox_r;
  logic signed [PIX_W-1:0] tx, ty, xlo, xhi, ylo, yhi, rowe;
  logic                    box_ok_nxt;
  logic [LANE_LAT:2]       box_r;

  always_comb begin
    xlo = trunc_px(cx_r[0]);
    xhi = xlo;
    ylo = trunc_px(cy_r[0]);
    yhi = ylo;
    for (int i = 1; i < 4; i++) begin
      tx = trunc_px(cx_r[i]);
      ty = trunc_px(cy_r[i]);
      if (tx < xlo) xlo = tx;
      if (tx > xhi) xhi = tx;
      if (ty < ylo) ylo = ty;
      if (ty > yhi) yhi = ty;
    end
    bbox_nxt.bx0 = (xlo < 0)    ? '0   : xlo;
    bbox_nxt.bx1 = (xhi > XLIM) ? XLIM : xhi;
    bbox_nxt.by0 = (ylo < 0)    ? '0   : ylo;
    bbox_nxt.by1 = (yhi > YLIM) ? YLIM : yhi;
    rowe         = $signed({{(PIX_W-ROW_W){1'b0}}, row_b_r});
    box_ok_nxt   = (bbox_r.bx0 <= bbox_r.bx1) && (bbox_r.by0 <= bbox_r.by1) &&
                   (rowe >= bbox_r.by0) && (rowe <= bbox_r.by1);
  end

  always_ff @(posedge clk) begin
    bbox_r                <= bbox_nxt;
    box_r[2]              <= box_ok_nxt;
    box_r[LANE_LAT:3]     <= box_r[LANE_LAT-1:2];
  end

  // Edges 3-0, 0-1, 1-2 and 2-3, one lane each.
  span_t             lane_res [0:3];
  logic [RFIX_W-1:0] rfix;

  assign rfix = {row_r, {FRAC_W{1'b0}}};

  for (genvar e = 0; e < 4; e++) begin : g_lane
    qss_edge_lane u_lane (
      .clk  (clk),
      .x1   (cx_r[(e + 3) % 4]),
      .y1   (cy_r[(e + 3) % 4]),
      .x2   (cx_r[e]),
      .y2   (cy_r[e]),
      .rfix (rfix),
      .res  (lane_res[e])
    );
  end

  // Merge: pairs first, then the whole quadrilateral; at least two hits are needed.
  span_t      pair0_r, pair1_r, fin_nxt, fin_r;
  logic [2:0] hit_cnt;
  logic       ok1_r, ok2_r;

  always_comb begin
    hit_cnt = {2'b0, lane_res[0].any} + {2'b0, lane_res[1].any} +
              {2'b0, lane_res[2].any} + {2'b0, lane_res[3].any};
    fin_nxt = merge_span(pair0_r, pair1_r);
  end

  always_ff @(posedge clk) begin
    pair0_r <= merge_span(lane_res[0], lane_res[1]);
    pair1_r <= merge_span(lane_res[2], lane_res[3]);
    ok1_r   <= box_r[LANE_LAT] && (hit_cnt >= 3'd2);
    fin_r   <= fin_nxt;
    ok2_r   <= ok1_r;
  end

  // Clamp to the screen width and decide validity.
  logic signed [PIX_W-1:0] cmin, cmax;
  logic                    span_ok;
  logic                    valid_r;
  logic [COL_W-1:0]        xmin_r, xmax_r;

  always_comb begin
    cmin    = (fin_r.lo < 0) ? '0 : ((fin_r.lo > XLIM) ? XLIM : fin_r.lo);
    cmax    = (fin_r.hi < 0) ? '0 : ((fin_r.hi > XLIM) ? XLIM : fin_r.hi);
    span_ok = ok2_r && (cmin <= cmax);
  end

  always_ff @(posedge clk) begin
    valid_r <= span_ok;
    xmin_r  <= span_ok ? cmin[COL_W-1:0] : '0;
    xmax_r  <= span_ok ? cmax[COL_W-1:0] : '0;
  end

  assign out_strobe     = v_r[OUT_IDX];
  assign out_span_valid = valid_r;
  assign out_span_xmin  = xmin_r;
  assign out_span_xmax  = xmax_r;

endmodule

/* sv/qss_edge_lane.sv */
`timescale 1ns / 1ps
// One edge of the quadrilateral: row intersection, exact division, ceiling and truncation.
// Depends on qss_pkg; fully pipelined, one row per cycle.
module qss_edge_lane (
  input  logic                          clk,
  input  qss_pkg::coord_t               x1,
  input  qss_pkg::coord_t               y1,
  input  qss_pkg::coord_t               x2,
  input  qss_pkg::coord_t               y2,
  input  logic [qss_pkg::RFIX_W-1:0]    rfix,
  output qss_pkg::span_t                res
);
  import qss_pkg::*;

  localparam int DW = CORNER_W + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int VW = DW + FRAC_W;
  localparam int TW = NW + 1;

  // Stage A: differences and hit test.
  logic signed [DW-1:0] yr, y1e, y2e;
  logic signed [DW-1:0] dy_a_r, dx_a_r, df_a_r;
  coord_t               x1_a_r;
  logic                 hit_a_r, hit_nxt;

  always_comb begin
    yr  = $signed({{(DW-RFIX_W){1'b0}}, rfix});
    y1e = {y1[CORNER_W-1], y1};
    y2e = {y2[CORNER_W-1], y2};
    hit_nxt = (y1e != y2e) &&
              (((y1e <= yr) && (yr <= y2e)) || ((y1e >= yr) && (yr >= y2e)));
  end

  always_ff @(posedge clk) begin
    dy_a_r  <= y2e - y1e;
    dx_a_r  <= {x2[CORNER_W-1], x2} - {x1[CORNER_W-1], x1};
    df_a_r  <= yr - y1e;
    x1_a_r  <= x1;
    hit_a_r <= hit_nxt;
  end

  // Stage B: the two products of the numerator.
  logic signed [CORNER_W+DW-1:0] p1_b_r;
  logic signed [PW-1:0]          p2_b_r;
  logic [DW-1:0]                 ady_b_r, ady_c_r;
  logic                          dyn_b_r, dyn_c_r, hit_b_r, hit_c_r;

  always_ff @(posedge clk) begin
    p1_b_r  <= x1_a_r * dy_a_r;
    p2_b_r  <= df_a_r * dx_a_r;
    ady_b_r <= dy_a_r[DW-1] ? $unsigned(-dy_a_r) : $unsigned(dy_a_r);
    dyn_b_r <= dy_a_r[DW-1];
    hit_b_r <= hit_a_r;
  end

  // Stage C: numerator sum.
  logic signed [NW-1:0] n_c_r;

  always_ff @(posedge clk) begin
    n_c_r   <= NW'(p1_b_r) + NW'(p2_b_r);
    ady_c_r <= ady_b_r;
    dyn_c_r <= dyn_b_r;
    hit_c_r <= hit_b_r;
  end

  // Stage D: magnitude and sign of the quotient, then restoring division,
  // one quotient bit per stage, most significant first.
  logic [NW-1:0]    a_nxt;
  logic             nz_nxt;
  logic [NW-1:0]    rem_r [0:QUO_W];
  logic [VW-1:0]    dv_r  [0:QUO_W];
  logic [QUO_W-1:0] q_r   [0:QUO_W];
  logic [QUO_W:0]   pos_r, neg_r, hit_r;
  logic [TW-1:0]    trial [0:QUO_W-1];

  always_comb begin
    a_nxt  = n_c_r[NW-1] ? $unsigned(-n_c_r) : $unsigned(n_c_r);
    nz_nxt = (n_c_r != '0);
    for (int k = 0; k < QUO_W; k++) begin
      trial[k] = {1'b0, rem_r[k]} - (TW'(dv_r[k]) << (QUO_W - 1 - k));
    end
  end

  // Stage E: ceiling and truncation toward zero of the signed quotient.
  logic signed [PIX_W-1:0] q17, qs;
  logic                    rnz;
  span_t                   res_nxt, res_r;

  always_comb begin
    q17         = $signed({1'b0, q_r[QUO_W]});
    rnz         = (rem_r[QUO_W] != '0);
    qs          = neg_r[QUO_W] ? -q17 : q17;
    res_nxt.any = hit_r[QUO_W];
    res_nxt.hi  = qs;
    res_nxt.lo  = qs + $signed(PIX_W'(pos_r[QUO_W] & rnz));
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= a_nxt;
    dv_r[0]  <= {ady_c_r, {FRAC_W{1'b0}}};
    q_r[0]   <= '0;
    pos_r[0] <= nz_nxt && (n_c_r[NW-1] == dyn_c_r);
    neg_r[0] <= nz_nxt && (n_c_r[NW-1] != dyn_c_r);
    hit_r[0] <= hit_c_r;
    for (int k = 0; k < QUO_W; k++) begin
      rem_r[k+1] <= trial[k][TW-1] ? rem_r[k] : trial[k][NW-1:0];
      dv_r[k+1]  <= dv_r[k];
      q_r[k+1]   <= {q_r[k][QUO_W-2:0], ~trial[k][TW-1]};
      pos_r[k+1] <= pos_r[k];
      neg_r[k+1] <= neg_r[k];
      hit_r[k+1] <= hit_r[k];
    end
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

/* sv/qss_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the quadrilateral row span block, bound to its top level.
// Depends on qss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qss_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_strobe,
  input logic                      out_span_valid,
  input logic [qss_pkg::COL_W-1:0] out_span_xmin,
  input logic [qss_pkg::COL_W-1:0] out_span_xmax
);
  import qss_pkg::*;

  // Every accepted transaction is answered after the fixed pipeline depth.
  `QSS_ASSERT_AFTER(a_latency, clk, rst_n, start && !busy, TOTAL_LAT, out_strobe, "result missing after fixed latency")

  // No result without a transaction accepted exactly that long before.
  `QSS_ASSERT_IMPLY(a_no_spurious, clk, rst_n, out_strobe, $past(start && !busy, TOTAL_LAT), "result without matching transaction")

  // An empty span reports both columns as zero.
  `QSS_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_strobe && !out_span_valid, (out_span_xmin == '0) && (out_span_xmax == '0), "empty span with nonzero columns")

  // A covered span never runs backward.
  `QSS_ASSERT_IMPLY(a_span_order, clk, rst_n, out_strobe && out_span_valid, out_span_xmin <= out_span_xmax, "span end before span start")

endmodule

bind quad_scanline_span qss_checker u_qss_checker (.*);
